// ===== hdl/w512_pkg.sv =====
// ----------------------------------------------------------------------------
// w512_pkg
// shared types and constants for the salted well512 generator
// ----------------------------------------------------------------------------
package w512_pkg;

    localparam int unsigned POOL_DEPTH = 16;
    localparam int unsigned ADDR_W     = $clog2(POOL_DEPTH);
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned IDX_W      = ADDR_W + 1;

    localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hDA44_2D24;
    localparam logic [WORD_W-1:0] HASH_MULT   = 32'h27D4_EB2D;
    localparam logic [WORD_W-1:0] HASH_XOR    = 32'd61;

    localparam logic [ADDR_W-1:0] OFS_Y = 4'd13;
    localparam logic [ADDR_W-1:0] OFS_Z = 4'd9;
    localparam logic [ADDR_W-1:0] OFS_Q = 4'd15;

    localparam logic [IDX_W-1:0] SALT_IDX = IDX_W'(POOL_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM = 2'd1;

    localparam logic FUNC_RESEED = 1'b0;
    localparam logic FUNC_DRAW   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAW_Y,
        ST_DRAW_Z,
        ST_DRAW_T,
        ST_DRAW_R,
        ST_DRAW_MUL,
        ST_DRAW_OUT,
        ST_HASH_A,
        ST_HASH_B,
        ST_HASH_C,
        ST_HASH_D
    } state_t;

endpackage

// ===== hdl/well512_salted_random_generator.sv =====
// ----------------------------------------------------------------------------
// well512_salted_random_generator
// well512 generator over a 16-word pool, salted output, hash-based reseed
// ----------------------------------------------------------------------------
// draw: steps through ST_DRAW_Y to ST_DRAW_OUT, one pool read a cycle
//   over the single registered read port, then one pass through the multiplier
// reseed: 17 hash passes through ST_HASH_A to ST_HASH_D, then done; the hash
//   multiply and the draw scaling share one 32x32 multiplier
// one request at a time; a new start is taken in the cycle done shows
// results come as a one-cycle done strobe, the receiver cannot stall
// async active-low reset clears pointer, salt, control and config registers and pool valid bits
module well512_salted_random_generator
(
    input  logic                            clk,
    input  logic                            rst_n,
    // request side
    input  logic                            start,
    output logic                            busy,
    input  logic                            func,
    input  logic [w512_pkg::WORD_W-1:0]     bound,
    // result side
    output logic                            done,
    output logic [w512_pkg::WORD_W-1:0]     word,
    output logic                            top_bit,
    output logic [w512_pkg::WORD_W-1:0]     scaled,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [w512_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [w512_pkg::WORD_W-1:0]     cfg_data
);
    import w512_pkg::*;

    // control state
    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      ptr_reg, ptr_next;
    logic [WORD_W-1:0]      salt_reg, salt_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [WORD_W-1:0]      seed_reg, stream_reg;
    logic                   done_reg, done_next;

    // datapath holding registers
    logic [WORD_W-1:0]      base_reg, base_next;
    logic [WORD_W-1:0]      hv_reg, hv_next;
    logic [WORD_W-1:0]      x_reg, x_next;
    logic [WORD_W-1:0]      mix_reg, mix_next;
    logic [WORD_W-1:0]      z_reg, z_next;
    logic [WORD_W-1:0]      tw_reg, tw_next;
    logic [WORD_W-1:0]      w_reg, w_next;
    logic [WORD_W-1:0]      bound_reg, bound_next;
    logic [2*WORD_W-1:0]    prod_reg;
    logic [WORD_W-1:0]      word_reg, word_next;
    logic [WORD_W-1:0]      scaled_reg, scaled_next;

    // pool memory and its valid bits (entries never written read as zero)
    logic [WORD_W-1:0]      pool_mem [POOL_DEPTH];
    logic [POOL_DEPTH-1:0]  valid_reg;
    logic [WORD_W-1:0]      rd_data_reg;
    logic                   rd_valid_reg;
    logic [ADDR_W-1:0]      rd_addr;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [WORD_W-1:0]      wr_data;
    logic [WORD_W-1:0]      rd_word;

    // shared multiplier operands
    logic [WORD_W-1:0]      mul_a, mul_b;

    // combinational scratch
    logic [WORD_W-1:0]      hin;
    logic [WORD_W-1:0]      hv2;
    logic [WORD_W-1:0]      zs;
    logic [WORD_W-1:0]      tv;
    logic [WORD_W-1:0]      rnew;
    logic [WORD_W-1:0]      hlo;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign word      = word_reg;
    assign top_bit   = word_reg[WORD_W-1];
    assign scaled    = scaled_reg;
    assign rd_word   = rd_valid_reg ? rd_data_reg : '0;

    // configuration registers, out-of-range indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= '0;
            stream_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SEED:   seed_reg   <= cfg_data;
                CFG_STREAM: stream_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // pool storage, write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pool_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= pool_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // the one multiplier, registered on its output
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
            salt_reg  <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            salt_reg  <= salt_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        hv_reg     <= hv_next;
        x_reg      <= x_next;
        mix_reg    <= mix_next;
        z_reg      <= z_next;
        tw_reg     <= tw_next;
        w_reg      <= w_next;
        bound_reg  <= bound_next;
        word_reg   <= word_next;
        scaled_reg <= scaled_next;
    end

    // sequencer and datapath
    always_comb
    begin
        state_next  = state_reg;
        ptr_next    = ptr_reg;
        salt_next   = salt_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        base_next   = base_reg;
        hv_next     = hv_reg;
        x_next      = x_reg;
        mix_next    = mix_reg;
        z_next      = z_reg;
        tw_next     = tw_reg;
        w_next      = w_reg;
        bound_next  = bound_reg;
        word_next   = word_reg;
        scaled_next = scaled_reg;
        rd_addr     = ptr_reg;
        wr_en       = 1'b0;
        wr_addr     = ptr_reg;
        wr_data     = '0;
        mul_a       = hv_reg;
        mul_b       = HASH_MULT;

        hin  = (idx_reg == SALT_IDX) ? stream_reg : base_reg + WORD_W'(idx_reg);
        hv2  = hv_reg + (hv_reg << 3);
        zs   = rd_word ^ (rd_word >> 11);
        tv   = mix_reg ^ zs;
        rnew = rd_word ^ mix_reg ^ tw_reg ^ (rd_word << 2) ^ (mix_reg << 18)
               ^ (z_reg << 28);
        hlo  = prod_reg[WORD_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                // read of pool[p] goes out on the accepting edge
                if (start)
                begin
                    bound_next = bound;
                    idx_next   = '0;
                    base_next  = seed_reg + (stream_reg << 4);
                    if (func == FUNC_DRAW)
                    begin
                        state_next = ST_DRAW_Y;
                    end
                    else
                    begin
                        state_next = ST_HASH_A;
                    end
                end
            end
            ST_DRAW_Y:
            begin
                x_next     = rd_word;
                rd_addr    = ptr_reg + OFS_Y;
                state_next = ST_DRAW_Z;
            end
            ST_DRAW_Z:
            begin
                mix_next   = x_reg ^ rd_word ^ (x_reg << 16) ^ (rd_word << 15);
                rd_addr    = ptr_reg + OFS_Z;
                state_next = ST_DRAW_T;
            end
            ST_DRAW_T:
            begin
                // new pool[p], tempered copy kept for the second write
                z_next     = zs;
                tw_next    = tv ^ ((tv << 5) & TEMPER_MASK);
                wr_en      = 1'b1;
                wr_addr    = ptr_reg;
                wr_data    = tv;
                rd_addr    = ptr_reg + OFS_Q;
                state_next = ST_DRAW_R;
            end
            ST_DRAW_R:
            begin
                wr_en      = 1'b1;
                wr_addr    = ptr_reg + OFS_Q;
                wr_data    = rnew;
                ptr_next   = ptr_reg + OFS_Q;
                w_next     = rnew ^ salt_reg;
                state_next = ST_DRAW_MUL;
            end
            ST_DRAW_MUL:
            begin
                mul_a      = bound_reg;
                mul_b      = w_reg;
                state_next = ST_DRAW_OUT;
            end
            ST_DRAW_OUT:
            begin
                done_next   = 1'b1;
                word_next   = w_reg;
                scaled_next = prod_reg[2*WORD_W-1:WORD_W];
                state_next  = ST_IDLE;
            end
            ST_HASH_A:
            begin
                hv_next    = (hin ^ HASH_XOR) ^ (hin >> 16);
                state_next = ST_HASH_B;
            end
            ST_HASH_B:
            begin
                hv_next    = hv2 ^ (hv2 >> 4);
                state_next = ST_HASH_C;
            end
            ST_HASH_C:
            begin
                state_next = ST_HASH_D;
            end
            ST_HASH_D:
            begin
                if (idx_reg == SALT_IDX)
                begin
                    salt_next   = hlo ^ (hlo >> 15);
                    ptr_next    = '0;
                    done_next   = 1'b1;
                    word_next   = '0;
                    scaled_next = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_reg[ADDR_W-1:0];
                    wr_data    = hlo ^ (hlo >> 15);
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_HASH_A;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/w512_checker.sv =====
// ----------------------------------------------------------------------------
// w512_checker
// port-level checks for the salted well512 generator
// ----------------------------------------------------------------------------
module w512_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            done,
    input  logic [w512_pkg::WORD_W-1:0]     word,
    input  logic                            top_bit,
    input  logic [w512_pkg::WORD_W-1:0]     scaled
);
    import w512_pkg::*;

    // an accepted request makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    // results only come out once the sequence has finished
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // each result strobe is followed by done low
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_top_bit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> top_bit == word[WORD_W-1])
        else $error("top bit does not match word");

    // a zero word scales to zero
    a_scaled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && word == '0 |-> scaled == '0)
        else $error("nonzero scaled value for zero word");

endmodule

bind well512_salted_random_generator w512_checker u_w512_checker (.*);
